### hw/rtl/weekly_event_table_scheduler_assert.svh
// assertion macros for the weekly event table scheduler
`ifndef WEEKLY_EVENT_TABLE_SCHEDULER_ASSERT_SVH
`define WEEKLY_EVENT_TABLE_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define WETS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WETS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/wets_pkg.sv
// types, codes and helpers shared by the weekly event table scheduler
package wets_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int OUT_LIMIT         = 16;
   localparam int HITS_W            = $clog2(OUT_LIMIT);
   localparam logic [5:0] ID_MAX    = 6'd31;

   localparam logic [1:0] REQ_SCHED_ON  = 2'd0;
   localparam logic [1:0] REQ_SCHED_OFF = 2'd1;
   localparam logic [1:0] REQ_REMOVE    = 2'd2;
   localparam logic [1:0] REQ_TICK      = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BOUNDS = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   localparam logic [3:0] DAY_SUN     = 4'd0;
   localparam logic [3:0] DAY_MON     = 4'd1;
   localparam logic [3:0] DAY_FRI     = 4'd5;
   localparam logic [3:0] DAY_SAT     = 4'd6;
   localparam logic [3:0] DAY_EVERY   = 4'd7;
   localparam logic [3:0] DAY_WEEKDAY = 4'd8;
   localparam logic [3:0] DAY_WEEKEND = 4'd9;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [5:0]  light_id;
      logic [3:0]  day_code;
      logic [10:0] minute_of_day;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic       cmd_valid;
      logic       cmd_on;
      logic [4:0] cmd_light_id;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic [4:0]  light_id;
      logic [3:0]  day_code;
      logic [10:0] minute;
      logic        turn_on;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   function automatic logic day_match(logic [3:0] code, logic [3:0] today);
      logic hit;
      hit = (code == DAY_EVERY) || (code == today) ||
            ((code == DAY_WEEKEND) && ((today == DAY_SAT) || (today == DAY_SUN))) ||
            ((code == DAY_WEEKDAY) && (today >= DAY_MON) && (today <= DAY_FRI));
      return hit;
   endfunction

endpackage

### hw/rtl/wets_if.sv
// valid/ready channel interfaces for requests and responses
interface wets_req_if;
   logic                      valid;
   logic                      ready;
   wets_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wets_rsp_if;
   logic                      valid;
   logic                      ready;
   wets_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/weekly_event_table_scheduler.sv
// light schedule table: insert, remove and per-minute due scan, one entry per cycle while not stalled
// a schedule with an id above 31 skips the scan and answers from the flush state; other
// requests scan the table one entry per cycle through the registered memory read; the scan
// holds on a second due entry, and the final response waits, while the response side stalls
// one transaction at a time: a new request is taken only in idle
// reset clears the entry valid bits and the state, counter and valid flags; no clearing pass
module weekly_event_table_scheduler #(
   parameter int TABLE_ENTRIES = wets_pkg::TABLE_ENTRIES_DEF
) (
   input logic      clock,
   input logic      reset,
   wets_req_if.sink   req_chan,
   wets_rsp_if.source rsp_chan
);
   import wets_pkg::*;

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   state_type state_ff, state_in;

   // latched request
   logic [1:0]  op_ff;
   logic [5:0]  lid_ff;
   logic [3:0]  day_ff;
   logic [10:0] min_ff;

   // scan pipeline
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;
   entry_type     rd_data_ff;

   // pending due entry, held until we know whether it is the final one
   logic              pend_vld_ff, pend_vld_in;
   logic              pend_on_ff, pend_on_in;
   logic [4:0]        pend_id_ff, pend_id_in;
   logic [HITS_W-1:0] hits_ff, hits_in;
   logic [1:0]        fin_status_ff, fin_status_in;

   logic            out_vld_ff, out_vld_in;
   rsp_payload_type out_ff, out_in;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   entry_type                mem_ram [TABLE_ENTRIES];

   logic req_fire, out_free, oob;
   logic is_sched, cur_vld, sched_free, rm_hit, tk_hit, at_end, stall, done;
   logic rd_en, wr_en, clr_en;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = out_vld_ff;
   assign rsp_chan.payload = out_ff;
   assign out_free         = !out_vld_ff || rsp_chan.ready;

   assign oob = ((req_chan.payload.req_type == REQ_SCHED_ON) ||
                 (req_chan.payload.req_type == REQ_SCHED_OFF)) &&
                (req_chan.payload.light_id > ID_MAX);

   // check stage: entry at chk_idx_ff against the latched request
   assign is_sched   = (op_ff == REQ_SCHED_ON) || (op_ff == REQ_SCHED_OFF);
   assign cur_vld    = valid_ff[chk_idx_ff];
   assign sched_free = is_sched && !cur_vld;
   assign rm_hit     = (op_ff == REQ_REMOVE) && cur_vld &&
                       ({1'b0, rd_data_ff.light_id} == lid_ff) &&
                       (rd_data_ff.day_code == day_ff) && (rd_data_ff.minute == min_ff);
   assign tk_hit     = (op_ff == REQ_TICK) && cur_vld &&
                       day_match(rd_data_ff.day_code, day_ff) &&
                       (rd_data_ff.minute == min_ff);
   assign at_end     = (chk_idx_ff == IW'(TABLE_ENTRIES - 1));
   // a second due entry needs the output register for the one already pending
   assign stall      = chk_vld_ff && tk_hit && pend_vld_ff && !out_free;
   assign done       = chk_vld_ff && !stall &&
                       (sched_free || rm_hit || at_end ||
                        (tk_hit && (hits_ff == HITS_W'(OUT_LIMIT - 1))));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = oob ? ST_FLUSH : ST_SCAN;
         end
         ST_SCAN: begin
            if (done) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      cnt_in        = cnt_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      pend_vld_in   = pend_vld_ff;
      pend_on_in    = pend_on_ff;
      pend_id_in    = pend_id_ff;
      hits_in       = hits_ff;
      fin_status_in = fin_status_ff;
      out_vld_in    = out_vld_ff && !rsp_chan.ready;
      out_in        = out_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      clr_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in        = '0;
               chk_vld_in    = 1'b0;
               pend_vld_in   = 1'b0;
               hits_in       = '0;
               fin_status_in = oob ? STATUS_BOUNDS : STATUS_OK;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               rd_en      = (cnt_ff < CW'(TABLE_ENTRIES));
               chk_vld_in = rd_en;
               chk_idx_in = cnt_ff[IW-1:0];
               if (rd_en) cnt_in = cnt_ff + CW'(1);
               if (chk_vld_ff) begin
                  wr_en  = sched_free;
                  clr_en = rm_hit;
                  if (tk_hit) begin
                     if (pend_vld_ff) begin
                        out_vld_in          = 1'b1;
                        out_in.status       = STATUS_OK;
                        out_in.cmd_valid    = 1'b1;
                        out_in.cmd_on       = pend_on_ff;
                        out_in.cmd_light_id = pend_id_ff;
                        out_in.last         = 1'b0;
                     end
                     pend_vld_in = 1'b1;
                     pend_on_in  = rd_data_ff.turn_on;
                     pend_id_in  = rd_data_ff.light_id;
                     hits_in     = hits_ff + HITS_W'(1);
                  end
                  if (at_end && is_sched && !sched_free) fin_status_in = STATUS_FULL;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               pend_vld_in = 1'b0;
               if (pend_vld_ff) begin
                  out_in.status       = STATUS_OK;
                  out_in.cmd_valid    = 1'b1;
                  out_in.cmd_on       = pend_on_ff;
                  out_in.cmd_light_id = pend_id_ff;
               end else begin
                  out_in.status       = fin_status_ff;
                  out_in.cmd_valid    = 1'b0;
                  out_in.cmd_on       = 1'b0;
                  out_in.cmd_light_id = '0;
               end
               out_in.last = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         chk_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         hits_ff     <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         chk_vld_ff  <= chk_vld_in;
         pend_vld_ff <= pend_vld_in;
         hits_ff     <= hits_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_chan.payload.req_type;
         lid_ff <= req_chan.payload.light_id;
         day_ff <= req_chan.payload.day_code;
         min_ff <= req_chan.payload.minute_of_day;
      end
      chk_idx_ff    <= chk_idx_in;
      pend_on_ff    <= pend_on_in;
      pend_id_ff    <= pend_id_in;
      fin_status_ff <= fin_status_in;
      out_ff        <= out_in;
   end

   // entry table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[chk_idx_ff] <= '{light_id: lid_ff[4:0], day_code: day_ff,
                                  minute: min_ff, turn_on: (op_ff == REQ_SCHED_ON)};
      end
      if (rd_en) rd_data_ff <= mem_ram[cnt_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[chk_idx_ff] <= 1'b1;
      end else if (clr_en) begin
         valid_ff[chk_idx_ff] <= 1'b0;
      end
   end

`include "weekly_event_table_scheduler_assert.svh"

   `WETS_ASSERT_NEXT(a_fire_leaves_idle, req_fire, state_ff != ST_IDLE,
      "accepted request did not start work")
   `WETS_ASSERT_SAME(a_idle_no_pending, state_ff == ST_IDLE, !pend_vld_ff,
      "pending due entry left behind in idle")
   `WETS_ASSERT_SAME(a_plain_rsp_is_last, out_vld_ff && !out_ff.cmd_valid, out_ff.last,
      "response without command is not final")
   `WETS_ASSERT_SAME(a_table_write_scan, wr_en || clr_en, state_ff == ST_SCAN && chk_vld_ff,
      "table changed outside the scan check stage")

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// testbench for the weekly event table scheduler: schedule, remove and tick traffic
module tb_top;
   import wets_pkg::*;

   localparam int SLOTS        = TABLE_ENTRIES_DEF;
   localparam int DRAIN_CYCLES = 2 * (SLOTS + 3);
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 35;

   class light_table_scoreboard;
      entry_type       slots [SLOTS];
      bit              slot_used [SLOTS];
      rsp_payload_type pending_rsps [$];
      int unsigned     fail_count;

      function bit due_today(logic [3:0] entry_day, logic [3:0] today);
         case (entry_day)
            DAY_EVERY: begin
               return 1'b1;
            end
            DAY_WEEKDAY: begin
               return (today == entry_day) || ((today >= DAY_MON) && (today <= DAY_FRI));
            end
            DAY_WEEKEND: begin
               return (today == entry_day) || (today == DAY_SAT) || (today == DAY_SUN);
            end
            default: begin
               return today == entry_day;
            end
         endcase
      endfunction

      function int used_count();
         int n;
         n = 0;
         foreach (slot_used[i]) n += slot_used[i];
         return n;
      endfunction

      // random valid entry, for removes and ticks that hit something
      function bit pick_used(output entry_type e);
         int idx [$];
         e = '0;
         foreach (slot_used[i]) if (slot_used[i]) idx.push_back(i);
         if (idx.size() == 0) return 1'b0;
         e = slots[idx[$urandom_range(0, idx.size() - 1)]];
         return 1'b1;
      endfunction

      function void note_request(req_payload_type rq);
         rsp_payload_type r;
         int              free_slot;
         int              hits;
         bit              done;
         r = '0;
         r.last = 1'b1;
         case (rq.req_type)
            REQ_SCHED_ON, REQ_SCHED_OFF: begin
               free_slot = -1;
               for (int i = SLOTS - 1; i >= 0; i--) if (!slot_used[i]) free_slot = i;
               if (rq.light_id > ID_MAX) begin
                  r.status = STATUS_BOUNDS;
               end else if (free_slot < 0) begin
                  r.status = STATUS_FULL;
               end else begin
                  slot_used[free_slot]        = 1'b1;
                  slots[free_slot].light_id   = rq.light_id[4:0];
                  slots[free_slot].day_code   = rq.day_code;
                  slots[free_slot].minute     = rq.minute_of_day;
                  slots[free_slot].turn_on    = (rq.req_type == REQ_SCHED_ON);
               end
               pending_rsps.push_back(r);
            end
            REQ_REMOVE: begin
               done = 1'b0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!done && slot_used[i] && ({1'b0, slots[i].light_id} == rq.light_id) &&
                      (slots[i].day_code == rq.day_code) &&
                      (slots[i].minute == rq.minute_of_day)) begin
                     slot_used[i] = 1'b0;
                     done = 1'b1;
                  end
               end
               pending_rsps.push_back(r);
            end
            default: begin
               hits = 0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (hits < OUT_LIMIT && slot_used[i] &&
                      due_today(slots[i].day_code, rq.day_code) &&
                      (slots[i].minute == rq.minute_of_day)) begin
                     r.cmd_valid    = 1'b1;
                     r.cmd_on       = slots[i].turn_on;
                     r.cmd_light_id = slots[i].light_id;
                     r.last         = 1'b0;
                     pending_rsps.push_back(r);
                     hits++;
                  end
               end
               if (hits == 0) begin
                  pending_rsps.push_back(r);
               end else begin
                  r = pending_rsps.pop_back();
                  r.last = 1'b1;
                  pending_rsps.push_back(r);
               end
            end
         endcase
      endfunction

      function void report(string what, rsp_payload_type want, rsp_payload_type got);
         fail_count++;
         if (fail_count <= 10)
            $display({"%0t %s: expected status=%0d cmd_valid=%0d cmd_on=%0d id=%0d last=%0d,",
                      " got status=%0d cmd_valid=%0d cmd_on=%0d id=%0d last=%0d"},
                     $realtime, what, want.status, want.cmd_valid, want.cmd_on,
                     want.cmd_light_id, want.last, got.status, got.cmd_valid, got.cmd_on,
                     got.cmd_light_id, got.last);
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_rsps.size() == 0) begin
            report("unexpected response", '0, got);
            return;
         end
         want = pending_rsps.pop_front();
         if (got.status !== want.status || got.cmd_valid !== want.cmd_valid ||
             got.cmd_on !== want.cmd_on || got.cmd_light_id !== want.cmd_light_id ||
             got.last !== want.last)
            report("response mismatch", want, got);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   wets_req_if req_if ();
   wets_rsp_if rsp_if ();

   weekly_event_table_scheduler u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   light_table_scoreboard scoreboard = new;
   int unsigned           req_idle_pct = 27;
   int unsigned           rsp_idle_pct = 49;
   int unsigned           cycle_count  = 0;
   logic [10:0]           minute_pool [4];
   logic [3:0]            day;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // response side: check each response, then stall at random
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         scoreboard.check_response(rsp_if.payload);
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   task automatic send_request(input logic [1:0] kind, input logic [5:0] id,
                               input logic [3:0] day, input logic [10:0] minute);
      req_payload_type rq;
      rq.req_type      = kind;
      rq.light_id      = id;
      rq.day_code      = day;
      rq.minute_of_day = minute;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= rq;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      scoreboard.note_request(rq);
   endtask

   function automatic logic [10:0] pick_minute();
      if ($urandom_range(0, 99) < 80) return minute_pool[$urandom_range(0, 3)];
      return 11'($urandom_range(0, 2047));
   endfunction

   task automatic random_requests(input int count);
      entry_type   e;
      int unsigned roll;
      int unsigned sched_pct;
      int unsigned remove_pct;
      logic [3:0]  day;
      logic [10:0] minute;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         // lean toward removes when the table is nearly full
         sched_pct  = (scoreboard.used_count() >= 12) ? 35 : 50;
         remove_pct = (scoreboard.used_count() >= 12) ? 40 : 20;
         if (roll < sched_pct) begin
            day = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 9)) :
                                                  4'($urandom_range(10, 15));
            send_request($urandom_range(0, 1) ? REQ_SCHED_ON : REQ_SCHED_OFF,
                         ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 31)) :
                                                         6'($urandom_range(32, 63)),
                         day, pick_minute());
         end else if (roll < sched_pct + remove_pct) begin
            if ($urandom_range(0, 99) < 70 && scoreboard.pick_used(e))
               send_request(REQ_REMOVE, {1'b0, e.light_id}, e.day_code, e.minute);
            else
               send_request(REQ_REMOVE, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                            pick_minute());
         end else begin
            day    = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 6)) :
                                                     4'($urandom_range(7, 15));
            minute = pick_minute();
            if ($urandom_range(0, 99) < 60 && scoreboard.pick_used(e)) begin
               minute = e.minute;
               if ($urandom_range(0, 1) && e.day_code <= DAY_SAT) day = e.day_code;
            end
            send_request(REQ_TICK, 6'($urandom_range(0, 63)), day, minute);
         end
      end
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      minute_pool[0] = 11'd0;
      minute_pool[1] = 11'd1439;
      minute_pool[2] = 11'd2047;
      minute_pool[3] = 11'($urandom_range(1, 1438));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // id out of range, tick and remove on an empty table
      send_request(REQ_SCHED_ON, 6'd32, DAY_SUN, 11'd0);
      send_request(REQ_SCHED_OFF, 6'd63, 4'd15, 11'd2047);
      send_request(REQ_TICK, 6'd0, DAY_SUN, 11'd0);
      send_request(REQ_REMOVE, 6'd0, DAY_SUN, 11'd0);
      // fill every entry so that one saturday tick makes all of them due
      for (int i = 0; i < SLOTS; i++) begin
         case (i % 3)
            0: day = DAY_SAT;
            1: day = DAY_EVERY;
            default: day = DAY_WEEKEND;
         endcase
         send_request((i % 2) ? REQ_SCHED_OFF : REQ_SCHED_ON,
                      (i == SLOTS - 1) ? 6'd31 : 6'(i * 2), day, 11'd1439);
      end
      send_request(REQ_SCHED_ON, 6'd17, DAY_WEEKDAY, 11'd2047);
      send_request(REQ_TICK, 6'd0, DAY_SAT, 11'd1439);
      send_request(REQ_TICK, 6'd0, DAY_SUN, 11'd1439);
      send_request(REQ_REMOVE, 6'd0, DAY_SAT, 11'd1439);
      // day code above the weekend code, and tick codes past saturday
      send_request(REQ_SCHED_OFF, 6'd9, 4'd15, 11'd2047);
      send_request(REQ_TICK, 6'd63, 4'd15, 11'd2047);
      send_request(REQ_TICK, 6'd0, DAY_WEEKDAY, 11'd1439);

      random_requests(RANDOM_ITEMS);
      req_idle_pct = 49;
      rsp_idle_pct = 27;
      random_requests(RANDOM_ITEMS);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_requests(RANDOM_ITEMS);
      req_if.valid <= 1'b0;

      while (scoreboard.pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
